// ----- src/pixel_to_direction_rotation_chain_defines.svh -----
// Assertion macros used by the rotation chain RTL.
`ifndef PIXEL_TO_DIRECTION_ROTATION_CHAIN_DEFINES_SVH
`define PIXEL_TO_DIRECTION_ROTATION_CHAIN_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define P2D_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check.
`define P2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define P2D_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define P2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/p2d_pkg.sv -----
`default_nettype none
package p2d_pkg;

   // Default number of CORDIC micro-rotations.
   localparam int CORDIC_STAGES_DEFAULT = 24;

   // Start value of the CORDIC, the 32-stage gain in Q1.30.
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // Number of rotation steps in the chain, the final quarter turn excluded.
   localparam int NUM_STEPS = 11;

   // Input beat.
   typedef struct packed {
      logic [31:0]        az_angle;
      logic [31:0]        el_angle;
      logic [31:0]        roll_angle;
      logic signed [19:0] image_x;
      logic signed [19:0] image_y;
   } req_data_type;

   // Result beat.
   typedef struct packed {
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic               saturated;
   } rsp_data_type;

   // Register map.
   typedef enum logic [2:0] {
      REG_ZERO_AZ_EL          = 3'd0,
      REG_ZERO_ROLL_DEROTATOR = 3'd1,
      REG_FLEXURE_COEFFS      = 3'd2,
      REG_TILTS_COLL_ROLL     = 3'd3,
      REG_TILTS_ELEV_AXIS     = 3'd4,
      REG_AZ_AXIS_TILT_EAST   = 3'd5,
      REG_PIXEL_SCALE         = 3'd6,
      REG_FLIP_MODE           = 3'd7
   } csr_index_type;

   // Axis of one rotation step.
   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   // Axis used by each step of the chain.
   function automatic axis_type step_axis(input int k);
      axis_type ax;
      case (k % 3)
         0:       ax = AXIS_Y;
         1:       ax = AXIS_X;
         default: ax = AXIS_Z;
      endcase
      return ax;
   endfunction

   // Arctangent table, binary angles.
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Clamp a CORDIC output to plus or minus one in Q1.30.
   function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd1073741824) begin
         r = 32'sd1073741824;
      end else if (v < -34'sd1073741824) begin
         r = -32'sd1073741824;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Saturate to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/p2d_delay.sv -----
`default_nettype none
module p2d_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic [WIDTH-1:0] d_in,
   output logic      [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   // Shift line; every tap is a register.
   always_ff @(posedge clock) begin
      line_ff[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign d_out = line_ff[DEPTH-1];

endmodule
`default_nettype wire

// ----- src/p2d_cordic.sv -----
`default_nettype none
module p2d_cordic #(
   parameter int STAGES = p2d_pkg::CORDIC_STAGES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic [31:0]        angle_in,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);

   logic signed [33:0] x_ff [STAGES+1];
   logic signed [33:0] y_ff [STAGES+1];
   logic signed [32:0] z_ff [STAGES+1];
   logic [1:0]         q_ff [STAGES+1];

   logic [31:0]        turn;
   logic signed [33:0] cc;
   logic signed [33:0] ss;

   // Fold the angle into one quadrant centered on zero.
   assign turn = angle_in + 32'h2000_0000;

   always_ff @(posedge clock) begin
      x_ff[0] <= p2d_pkg::CORDIC_GAIN;
      y_ff[0] <= '0;
      z_ff[0] <= $signed({3'b000, turn[29:0]}) - 33'sd536870912;
      q_ff[0] <= turn[31:30];
   end

   // One micro-rotation per register stage.
   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic signed [32:0] ATAN = 33'(p2d_pkg::atan_entry(5'(i)));
      logic signed [33:0] dx;
      logic signed [33:0] dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         q_ff[i+1] <= q_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - ATAN;
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + ATAN;
         end
      end
   end

   // Undo the quadrant fold.
   always_comb begin
      case (q_ff[STAGES])
         2'd0: begin
            cc = x_ff[STAGES];
            ss = y_ff[STAGES];
         end
         2'd1: begin
            cc = -y_ff[STAGES];
            ss = x_ff[STAGES];
         end
         2'd2: begin
            cc = -x_ff[STAGES];
            ss = -y_ff[STAGES];
         end
         default: begin
            cc = y_ff[STAGES];
            ss = -x_ff[STAGES];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_out <= p2d_pkg::clamp_unit(cc);
      sin_out <= p2d_pkg::clamp_unit(ss);
   end

endmodule
`default_nettype wire

// ----- src/p2d_rotate.sv -----
`default_nettype none
module p2d_rotate (
   input  wire logic               clock,
   input  wire logic signed [32:0] p_in,
   input  wire logic signed [32:0] q_in,
   input  wire logic signed [31:0] c_in,
   input  wire logic signed [31:0] s_in,
   output logic signed [32:0]      p_out,
   output logic signed [32:0]      q_out,
   output logic                    sat_out
);

   localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
   localparam logic signed [35:0] LIMIT      = 36'sd4294967295;

   logic signed [64:0] pc_ff, qs_ff, qc_ff, ps_ff;
   logic signed [65:0] np_sum, nq_sum;
   logic signed [35:0] np, nq;
   logic               p_over, q_over;

   // Products first.
   always_ff @(posedge clock) begin
      pc_ff <= p_in * c_in;
      qs_ff <= q_in * s_in;
      qc_ff <= q_in * c_in;
      ps_ff <= p_in * s_in;
   end

   // Sum, round half up, then clamp the rotated pair.
   assign np_sum = 66'(pc_ff) + 66'(qs_ff) + ROUND_HALF;
   assign nq_sum = 66'(qc_ff) - 66'(ps_ff) + ROUND_HALF;
   assign np     = np_sum[65:30];
   assign nq     = nq_sum[65:30];
   assign p_over = (np > LIMIT) || (np < -LIMIT);
   assign q_over = (nq > LIMIT) || (nq < -LIMIT);

   always_ff @(posedge clock) begin
      if (np > LIMIT) begin
         p_out <= LIMIT[32:0];
      end else if (np < -LIMIT) begin
         p_out <= -(LIMIT[32:0]);
      end else begin
         p_out <= np[32:0];
      end
      if (nq > LIMIT) begin
         q_out <= LIMIT[32:0];
      end else if (nq < -LIMIT) begin
         q_out <= -(LIMIT[32:0]);
      end else begin
         q_out <= nq[32:0];
      end
      sat_out <= p_over | q_over;
   end

endmodule
`default_nettype wire

// ----- src/pixel_to_direction_rotation_chain.sv -----
// Pixel-to-direction rotation chain. One beat is taken on every cycle in which
// start is high (busy is always low) and its result appears on rsp_data with
// rsp_strobe; beats leave in the order they came and the receiver cannot hold
// them off. The pipeline is made of two CORDIC layers in series (the flexure
// angles need the elevation and roll sines first), two multiplier stages for
// the flexure terms, eleven rotation stages of two registers each and one
// output stage. Registers sit on the APB port at byte address 8*i and must
// only be written while no beat is in flight.
`default_nettype none
`include "pixel_to_direction_rotation_chain_defines.svh"
module pixel_to_direction_rotation_chain #(
   parameter int CORDIC_STAGES = p2d_pkg::CORDIC_STAGES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire p2d_pkg::req_data_type req_data,
   output logic                       rsp_strobe,
   output p2d_pkg::rsp_data_type      rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [5:0]            paddr,
   input  wire logic [63:0]           pwdata,
   output logic [63:0]                prdata,
   output logic                       pready
);

   localparam int CLAT      = CORDIC_STAGES + 2;
   localparam int TOTAL_LAT = 2 * CLAT + 26;
   localparam int NSTEP     = p2d_pkg::NUM_STEPS;

   // Configuration registers.
   logic [63:0] zero_az_el_ff, zero_roll_derot_ff, flexure_ff, tilts_cr_ff, tilts_ea_ff;
   logic [31:0] tilt_east_ff, pixel_scale_ff;
   logic [1:0]  flip_mode_ff;
   p2d_pkg::csr_index_type csr_index;
   logic        csr_write;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_index = p2d_pkg::csr_index_type'(paddr[5:3]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_az_el_ff      <= '0;
         zero_roll_derot_ff <= '0;
         flexure_ff         <= '0;
         tilts_cr_ff        <= '0;
         tilts_ea_ff        <= '0;
         tilt_east_ff       <= '0;
         pixel_scale_ff     <= '0;
         flip_mode_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            p2d_pkg::REG_ZERO_AZ_EL:          zero_az_el_ff      <= pwdata;
            p2d_pkg::REG_ZERO_ROLL_DEROTATOR: zero_roll_derot_ff <= pwdata;
            p2d_pkg::REG_FLEXURE_COEFFS:      flexure_ff         <= pwdata;
            p2d_pkg::REG_TILTS_COLL_ROLL:     tilts_cr_ff        <= pwdata;
            p2d_pkg::REG_TILTS_ELEV_AXIS:     tilts_ea_ff        <= pwdata;
            p2d_pkg::REG_AZ_AXIS_TILT_EAST:   tilt_east_ff       <= pwdata[31:0];
            p2d_pkg::REG_PIXEL_SCALE:         pixel_scale_ff     <= pwdata[31:0];
            p2d_pkg::REG_FLIP_MODE:           flip_mode_ff       <= pwdata[1:0];
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_index)
         p2d_pkg::REG_ZERO_AZ_EL:          prdata = zero_az_el_ff;
         p2d_pkg::REG_ZERO_ROLL_DEROTATOR: prdata = zero_roll_derot_ff;
         p2d_pkg::REG_FLEXURE_COEFFS:      prdata = flexure_ff;
         p2d_pkg::REG_TILTS_COLL_ROLL:     prdata = tilts_cr_ff;
         p2d_pkg::REG_TILTS_ELEV_AXIS:     prdata = tilts_ea_ff;
         p2d_pkg::REG_AZ_AXIS_TILT_EAST:   prdata = {32'd0, tilt_east_ff};
         p2d_pkg::REG_PIXEL_SCALE:         prdata = {32'd0, pixel_scale_ff};
         p2d_pkg::REG_FLIP_MODE:           prdata = {62'd0, flip_mode_ff};
      endcase
   end

   // Valid bits travel alongside the data.
   logic [TOTAL_LAT-1:0] valid_ff;
   logic [TOTAL_LAT-1:0] valid_in;

   assign valid_in = {valid_ff[TOTAL_LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe = valid_ff[TOTAL_LAT-1];

   // Front stage: offset angles, flipped image coordinates.
   logic [31:0]        a_ang, l_ang, r_ang;
   logic [31:0]        bank_ang_ff [NSTEP];
   logic signed [20:0] ix_ff, iy_ff;

   assign a_ang = req_data.az_angle - zero_az_el_ff[31:0];
   assign l_ang = zero_az_el_ff[63:32] - req_data.el_angle;
   assign r_ang = zero_roll_derot_ff[31:0] - req_data.roll_angle;

   always_ff @(posedge clock) begin
      bank_ang_ff[0]  <= l_ang;
      bank_ang_ff[1]  <= r_ang;
      bank_ang_ff[2]  <= 32'd0 - zero_roll_derot_ff[63:32];
      bank_ang_ff[3]  <= 32'd0 - tilts_cr_ff[31:0];
      bank_ang_ff[4]  <= 32'd0 - r_ang;
      bank_ang_ff[5]  <= 32'd0 - tilts_cr_ff[63:32];
      bank_ang_ff[6]  <= 32'd0 - l_ang;
      bank_ang_ff[7]  <= 32'd0 - tilts_ea_ff[31:0];
      bank_ang_ff[8]  <= 32'd0 - a_ang;
      bank_ang_ff[9]  <= 32'd0 - tilts_ea_ff[63:32];
      bank_ang_ff[10] <= 32'd0 - tilt_east_ff;
      ix_ff <= flip_mode_ff[0] ? -21'(req_data.image_x) : 21'(req_data.image_x);
      iy_ff <= flip_mode_ff[1] ? -21'(req_data.image_y) : 21'(req_data.image_y);
   end

   // First CORDIC layer: every angle known at the front stage.
   logic signed [31:0] bank_c [NSTEP];
   logic signed [31:0] bank_s [NSTEP];

   for (genvar j = 0; j < NSTEP; j++) begin : g_bank
      p2d_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
         .clock    (clock),
         .angle_in (bank_ang_ff[j]),
         .cos_out  (bank_c[j]),
         .sin_out  (bank_s[j])
      );
   end

   // Tangent-plane coordinates: product, then round and saturate.
   logic signed [53:0] tx_prod_ff, ty_prod_ff;
   logic signed [53:0] tx_sum, ty_sum;
   logic signed [31:0] tx_ff, ty_ff;
   logic               tsat_ff;
   logic               tx_over, ty_over;

   always_ff @(posedge clock) begin
      tx_prod_ff <= ix_ff * $signed({1'b0, pixel_scale_ff});
      ty_prod_ff <= iy_ff * $signed({1'b0, pixel_scale_ff});
   end

   assign tx_sum  = tx_prod_ff + 54'sd8;
   assign ty_sum  = ty_prod_ff + 54'sd8;
   assign tx_over = ($signed(tx_sum[53:4]) > 50'sd2147483647)
                 || ($signed(tx_sum[53:4]) < -50'sd2147483648);
   assign ty_over = ($signed(ty_sum[53:4]) > 50'sd2147483647)
                 || ($signed(ty_sum[53:4]) < -50'sd2147483648);

   always_ff @(posedge clock) begin
      tx_ff   <= tx_over ? (tx_sum[53] ? 32'sh80000000 : 32'sh7FFFFFFF) : tx_sum[35:4];
      ty_ff   <= ty_over ? (ty_sum[53] ? 32'sh80000000 : 32'sh7FFFFFFF) : ty_sum[35:4];
      tsat_ff <= tx_over | ty_over;
   end

   // Flexure angles from the elevation and roll sines and cosines.
   localparam logic signed [63:0] HALF30 = 64'sd536870912;
   logic signed [31:0] fx, fy;
   logic signed [63:0] f1_sum, t_sum, f2_sum;
   logic [31:0]        pf1_ff, pf2_ff, flex_ang1_ff, flex_ang2;
   logic signed [31:0] t_ff;

   assign fx     = flexure_ff[31:0];
   assign fy     = flexure_ff[63:32];
   assign f1_sum = fx * bank_s[0] + HALF30;
   assign t_sum  = bank_c[0] * bank_s[1] + HALF30;
   assign f2_sum = fy * t_ff + HALF30;

   always_ff @(posedge clock) begin
      pf1_ff       <= f1_sum[61:30];
      t_ff         <= t_sum[61:30];
      pf2_ff       <= f2_sum[61:30];
      flex_ang1_ff <= 32'd0 - pf1_ff;
   end

   assign flex_ang2 = 32'd0 - pf2_ff;

   // Second CORDIC layer: the two flexure rotations.
   logic signed [31:0] step_c [NSTEP];
   logic signed [31:0] step_s [NSTEP];
   logic signed [31:0] flex2_c, flex2_s;

   p2d_cordic #(.STAGES(CORDIC_STAGES)) u_flex1 (
      .clock    (clock),
      .angle_in (flex_ang1_ff),
      .cos_out  (step_c[0]),
      .sin_out  (step_s[0])
   );

   p2d_cordic #(.STAGES(CORDIC_STAGES)) u_flex2 (
      .clock    (clock),
      .angle_in (flex_ang2),
      .cos_out  (flex2_c),
      .sin_out  (flex2_s)
   );

   p2d_delay #(.WIDTH(64), .DEPTH(2)) u_flex2_dly (
      .clock (clock),
      .d_in  ({flex2_c, flex2_s}),
      .d_out ({step_c[1], step_s[1]})
   );

   // Line up the fixed-angle sines and cosines with their rotation step.
   for (genvar k = 2; k < NSTEP; k++) begin : g_cs_dly
      p2d_delay #(.WIDTH(64), .DEPTH(CLAT + 2 + 2 * k)) u_dly (
         .clock (clock),
         .d_in  ({bank_c[k], bank_s[k]}),
         .d_out ({step_c[k], step_s[k]})
      );
   end

   // Starting vector, waiting for the flexure terms.
   logic signed [32:0] vx [NSTEP+1];
   logic signed [32:0] vy [NSTEP+1];
   logic signed [32:0] vz [NSTEP+1];
   logic               vsat [NSTEP+1];
   logic signed [31:0] tx_dly, ty_dly;

   p2d_delay #(.WIDTH(65), .DEPTH(2 * CLAT)) u_tan_dly (
      .clock (clock),
      .d_in  ({tx_ff, ty_ff, tsat_ff}),
      .d_out ({tx_dly, ty_dly, vsat[0]})
   );

   assign vx[0] = 33'(tx_dly);
   assign vy[0] = 33'(ty_dly);
   assign vz[0] = 33'sd268435456;

   // Rotation chain; the untouched component rides a two-stage delay.
   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      localparam p2d_pkg::axis_type AX = p2d_pkg::step_axis(k);
      logic signed [32:0] p_in, q_in, p_out, q_out, pass_in, pass_out;
      logic               rot_sat, pass_sat;

      if (AX == p2d_pkg::AXIS_Y) begin : g_y
         assign p_in    = vz[k];
         assign q_in    = vx[k];
         assign pass_in = vy[k];
         assign vz[k+1] = p_out;
         assign vx[k+1] = q_out;
         assign vy[k+1] = pass_out;
      end else if (AX == p2d_pkg::AXIS_X) begin : g_x
         assign p_in    = vy[k];
         assign q_in    = vz[k];
         assign pass_in = vx[k];
         assign vy[k+1] = p_out;
         assign vz[k+1] = q_out;
         assign vx[k+1] = pass_out;
      end else begin : g_z
         assign p_in    = vx[k];
         assign q_in    = vy[k];
         assign pass_in = vz[k];
         assign vx[k+1] = p_out;
         assign vy[k+1] = q_out;
         assign vz[k+1] = pass_out;
      end

      p2d_rotate u_rot (
         .clock   (clock),
         .p_in    (p_in),
         .q_in    (q_in),
         .c_in    (step_c[k]),
         .s_in    (step_s[k]),
         .p_out   (p_out),
         .q_out   (q_out),
         .sat_out (rot_sat)
      );

      p2d_delay #(.WIDTH(34), .DEPTH(2)) u_pass (
         .clock (clock),
         .d_in  ({pass_in, vsat[k]}),
         .d_out ({pass_out, pass_sat})
      );

      assign vsat[k+1] = pass_sat | rot_sat;
   end

   // Final quarter turn about Z and output saturation.
   logic signed [33:0] ox, oy, oz;
   logic               o_over;

   assign ox     = -(34'(vy[NSTEP]));
   assign oy     = 34'(vx[NSTEP]);
   assign oz     = 34'(vz[NSTEP]);
   assign o_over = (ox > 34'sd2147483647) || (ox < -34'sd2147483648)
                || (oy > 34'sd2147483647) || (oy < -34'sd2147483648)
                || (oz > 34'sd2147483647) || (oz < -34'sd2147483648);

   always_ff @(posedge clock) begin
      rsp_data.dir_x     <= p2d_pkg::sat32(ox);
      rsp_data.dir_y     <= p2d_pkg::sat32(oy);
      rsp_data.dir_z     <= p2d_pkg::sat32(oz);
      rsp_data.saturated <= vsat[NSTEP] | o_over;
   end

   // Every accepted beat comes out after the fixed latency, and nothing else does.
   `P2D_ASSERT_IMPLY(a_beat_delivered, clock, reset, start && !busy, ##TOTAL_LAT rsp_strobe, "accepted beat not delivered on time")
   `P2D_ASSERT_IMPLY(a_no_invented_beat, clock, reset, rsp_strobe, $past(start, TOTAL_LAT), "result strobe without an accepted beat")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
   import p2d_pkg::*;

   localparam int LATENCY = 2 * (CORDIC_STAGES_DEFAULT + 2) + 26;
   localparam longint QUARTER = 64'sd1 << 30;
   localparam longint ROT_LIM = (64'sd1 << 32) - 1;
   localparam longint S32_LO = -64'sd2147483648;
   localparam longint S32_HI = 64'sd2147483647;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_data_type req_data = '0;
   logic rsp_strobe;
   rsp_data_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [5:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;

   pixel_to_direction_rotation_chain dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // Shadow copy of the register file.
   logic [63:0] shadow_regs [8];
   rsp_data_type direction_queue [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;

   // Arctangent of 2^-i as binary angles.
   localparam logic [31:0] ARCTAN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   function automatic longint clip(input longint v, input longint lo, input longint hi,
                                   inout bit sat);
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic longint round_q30(input longint a, input longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
   endfunction

   // Sine and cosine in Q1.30 by CORDIC with quadrant folding.
   function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] t;
      longint x, y, z, dx, dy, cc, ss;
      bit ignore;
      t = ang + 32'h20000000;
      z = longint'({34'd0, t[29:0]}) - 64'sd536870912;
      x = 64'sd652032874;
      y = 0;
      ignore = 1'b0;
      for (int i = 0; i < CORDIC_STAGES_DEFAULT && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ARCTAN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ARCTAN[i]);
         end
      end
      case (t[31:30])
         2'd0: begin cc = x;  ss = y;  end
         2'd1: begin cc = -y; ss = x;  end
         2'd2: begin cc = -x; ss = -y; end
         default: begin cc = y; ss = -x; end
      endcase
      c = clip(cc, -QUARTER, QUARTER, ignore);
      s = clip(ss, -QUARTER, QUARTER, ignore);
   endfunction

   // Planar rotation: p' = p*c + q*s, q' = q*c - p*s.
   function automatic void rotate(inout longint p, inout longint q, input logic [31:0] phi,
                                  inout bit sat);
      longint c, s, np, nq;
      sin_cos(phi, c, s);
      np = (p * c + q * s + (64'sd1 << 29)) >>> 30;
      nq = (q * c - p * s + (64'sd1 << 29)) >>> 30;
      p = clip(np, -ROT_LIM, ROT_LIM, sat);
      q = clip(nq, -ROT_LIM, ROT_LIM, sat);
   endfunction

   // Expected direction vector for one pixel beat under the shadow registers.
   function automatic rsp_data_type predict_direction(input req_data_type d);
      rsp_data_type r;
      bit sat;
      logic [31:0] a, l, rr, phi;
      longint ix, iy, x, y, z, cl, sl, cr, sr, t, fx, fy;
      sat = 1'b0;
      a = d.az_angle - shadow_regs[REG_ZERO_AZ_EL][31:0];
      l = shadow_regs[REG_ZERO_AZ_EL][63:32] - d.el_angle;
      rr = shadow_regs[REG_ZERO_ROLL_DEROTATOR][31:0] - d.roll_angle;
      ix = longint'(d.image_x);
      iy = longint'(d.image_y);
      fx = longint'($signed(shadow_regs[REG_FLEXURE_COEFFS][31:0]));
      fy = longint'($signed(shadow_regs[REG_FLEXURE_COEFFS][63:32]));
      if (shadow_regs[REG_FLIP_MODE][0]) ix = -ix;
      if (shadow_regs[REG_FLIP_MODE][1]) iy = -iy;
      t = longint'({32'd0, shadow_regs[REG_PIXEL_SCALE][31:0]});
      x = clip((ix * t + 8) >>> 4, S32_LO, S32_HI, sat);
      y = clip((iy * t + 8) >>> 4, S32_LO, S32_HI, sat);
      z = 64'sd1 << 28;
      sin_cos(l, cl, sl);
      sin_cos(rr, cr, sr);
      // Flexure terms first, their angles depend on elevation and roll.
      phi = 32'd0 - 32'(round_q30(fx, sl));
      rotate(z, x, phi, sat);
      t = round_q30(cl, sr);
      phi = 32'd0 - 32'(round_q30(fy, t));
      rotate(y, z, phi, sat);
      rotate(x, y, 32'd0 - shadow_regs[REG_ZERO_ROLL_DEROTATOR][63:32], sat);
      rotate(z, x, 32'd0 - shadow_regs[REG_TILTS_COLL_ROLL][31:0], sat);
      rotate(y, z, 32'd0 - rr, sat);
      rotate(x, y, 32'd0 - shadow_regs[REG_TILTS_COLL_ROLL][63:32], sat);
      rotate(z, x, 32'd0 - l, sat);
      rotate(y, z, 32'd0 - shadow_regs[REG_TILTS_ELEV_AXIS][31:0], sat);
      rotate(x, y, 32'd0 - a, sat);
      rotate(z, x, 32'd0 - shadow_regs[REG_TILTS_ELEV_AXIS][63:32], sat);
      rotate(y, z, 32'd0 - shadow_regs[REG_AZ_AXIS_TILT_EAST][31:0], sat);
      // Final quarter turn about Z.
      t = x;
      x = -y;
      y = t;
      r.dir_x = 32'(clip(x, S32_LO, S32_HI, sat));
      r.dir_y = 32'(clip(y, S32_LO, S32_HI, sat));
      r.dir_z = 32'(clip(z, S32_LO, S32_HI, sat));
      r.saturated = sat;
      return r;
   endfunction

   // Register write over APB, mirrored into the shadow copy.
   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 6'(8 * int'(idx));
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_FLIP_MODE) value = value & 64'd3;
      else if (idx >= REG_AZ_AXIS_TILT_EAST) value = value & 64'hFFFFFFFF;
      shadow_regs[idx] = value;
   endtask

   // Wait for the pipeline to drain before touching registers.
   task automatic wait_drained();
      while (direction_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Send one beat, with a random gap ahead of it.
   task automatic send_pixel(input req_data_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (busy);
      direction_queue.push_back(predict_direction(d));
   endtask

   task automatic end_burst();
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic req_data_type random_pixel(input bit realistic);
      req_data_type d;
      d.az_angle = $urandom;
      d.el_angle = $urandom;
      d.roll_angle = $urandom;
      case ($urandom_range(5))
         0: begin d.image_x = 20'sh80000; d.image_y = 20'sh7FFFF; end
         1: begin d.image_x = 20'($urandom); d.image_y = 20'sh80000; end
         default: begin
            d.image_x = 20'($urandom);
            d.image_y = 20'($urandom);
            if (realistic) begin
               d.image_x = 20'($signed(d.image_x) >>> 8);
               d.image_y = 20'($signed(d.image_y) >>> 8);
            end
         end
      endcase
      return d;
   endfunction

   // Directed beats: angle and coordinate extremes under several register sets.
   task automatic test_directed();
      req_data_type d;
      logic [31:0] angs [4] = '{32'h0, 32'hFFFFFFFF, 32'h40000000, 32'h80000000};
      write_reg(REG_PIXEL_SCALE, 64'd4096);
      for (int f = 0; f < 4; f++) begin
         write_reg(REG_FLIP_MODE, 64'(f));
         for (int k = 0; k < 4; k++) begin
            d.az_angle = angs[k];
            d.el_angle = angs[(k + 1) % 4];
            d.roll_angle = angs[(k + 2) % 4];
            d.image_x = (k[0]) ? 20'sh7FFFF : 20'sh80000;
            d.image_y = (k[1]) ? 20'sh7FFFF : 20'sh80000;
            send_pixel(d);
         end
         end_burst();
         wait_drained();
      end
      // Largest scale; the first beat saturates the tangent values.
      write_reg(REG_PIXEL_SCALE, 64'hFFFFFFFF);
      d = '{32'h0, 32'h0, 32'h0, 20'sh7FFFF, 20'sh80000};
      send_pixel(d);
      d = '{32'h0, 32'h0, 32'h0, 20'sh0, 20'sh1};
      send_pixel(d);
      end_burst();
      wait_drained();
   endtask

   // Random beats under one register set.
   task automatic test_random(input int cfg_kind, input int idle_pct, input int n_items);
      logic [63:0] v;
      wait_drained();
      for (int i = 0; i < 8; i++) begin
         case (cfg_kind)
            0: v = '0;
            1: v = '1;
            2: v = {$urandom, $urandom};
            default: v = {32'($signed(16'($urandom))), 32'($signed(16'($urandom))) };
         endcase
         if (i == REG_PIXEL_SCALE && cfg_kind >= 2) v = (cfg_kind == 2) ? {32'd0, $urandom}
                                                                         : 64'($urandom_range(65535));
         write_reg(csr_index_type'(i), v);
      end
      send_idle_pct = idle_pct;
      for (int n = 0; n < n_items; n++) send_pixel(random_pixel(cfg_kind >= 3));
      end_burst();
   endtask

   // Compare every result beat against the oldest expected direction.
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_strobe) begin
         if (direction_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result beat %h", rsp_data);
         end else begin
            want = direction_queue.pop_front();
            if (rsp_data.dir_x !== want.dir_x || rsp_data.dir_y !== want.dir_y ||
                rsp_data.dir_z !== want.dir_z || rsp_data.saturated !== want.saturated) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                           want.dir_x, want.dir_y, want.dir_z, want.saturated, rsp_data.dir_x,
                           rsp_data.dir_y, rsp_data.dir_z, rsp_data.saturated);
            end
         end
      end
   end

   initial begin
      int idle_sched [3] = '{27, 65, 0};
      for (int i = 0; i < 8; i++) shadow_regs[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      for (int p = 0; p < 3; p++) begin
         test_random(0, idle_sched[p], 60);
         test_random(1, idle_sched[p], 60);
         test_random(2, idle_sched[p], 180);
         test_random(3, idle_sched[p], 250);
      end
      wait_drained();
      if (mismatch_count == 0 && direction_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
